// ===== rtl/dtfp_pkg.sv =====
`timescale 1ns / 1ps

package dtfp_pkg;

  // Upper bound on the reported length before the 16-bit field saturates.
  localparam logic [31:0] DefaultMaxLength = 32'd65535;

  // Entries in the queue between the front and the back end.
  localparam int unsigned QueueDepth = 2;

  localparam logic [15:0] CharMinus = 16'h002D;
  localparam logic [15:0] CharPlus  = 16'h002B;
  localparam logic [15:0] CharDot   = 16'h002E;
  localparam logic [15:0] CharZero  = 16'h0030;
  localparam logic [15:0] CharNine  = 16'h0039;

  // 0.1 in unsigned Q0.32, rounded up.
  localparam logic [31:0] TenthQ32 = 32'd429496730;
  localparam logic [31:0] IntLimit = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [15:0] ch;
    logic        last;
  } dtfp_in_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic [15:0]        used_length;
    logic               overflow;
  } dtfp_out_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_NEG,
    OP_POS,
    OP_INT,
    OP_DOT,
    OP_FRAC
  } dtfp_op_e;

  // One classified character on its way to the back end.
  typedef struct packed {
    dtfp_op_e    op;
    logic [3:0]  digit;
    logic        emit;
  } dtfp_entry_t;

endpackage

// ===== rtl/dtfp_front.sv =====
`timescale 1ns / 1ps

module dtfp_front import dtfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  dtfp_in_t    in_data_i,
  input  logic        q_full_i,
  output logic        push_o,
  output dtfp_entry_t push_data_o
);

  localparam logic [1:0] PhStart = 2'd0;
  localparam logic [1:0] PhInt   = 2'd1;
  localparam logic [1:0] PhFrac  = 2'd2;
  localparam logic [1:0] PhSkip  = 2'd3;

  logic [1:0] phase_q, phase_d;
  logic [1:0] next_phase;
  logic       in_accept;
  logic       is_digit;
  logic       taken;
  dtfp_op_e   op;

  assign in_stall_o = q_full_i;
  assign in_accept  = in_valid_i && !q_full_i;
  assign is_digit   = (in_data_i.ch >= CharZero) && (in_data_i.ch <= CharNine);

  always_comb begin
    taken      = 1'b0;
    op         = OP_NONE;
    next_phase = phase_q;
    unique case (phase_q) inside
      PhStart, PhInt: begin
        next_phase = PhInt;
        if (phase_q == PhStart && in_data_i.ch == CharMinus) begin
          op    = OP_NEG;
          taken = 1'b1;
        end else if (phase_q == PhStart && in_data_i.ch == CharPlus) begin
          op    = OP_POS;
          taken = 1'b1;
        end else if (is_digit) begin
          op    = OP_INT;
          taken = 1'b1;
        end else if (in_data_i.ch == CharDot) begin
          op         = OP_DOT;
          taken      = 1'b1;
          next_phase = PhFrac;
        end
      end
      PhFrac: begin
        if (is_digit) begin
          op    = OP_FRAC;
          taken = 1'b1;
        end
      end
      default: begin
        next_phase = PhSkip;
      end
    endcase
    // A rejected or final character closes the number.
    if (!taken || in_data_i.last) begin
      next_phase = in_data_i.last ? PhStart : PhSkip;
    end
  end

  always_comb begin
    phase_d = phase_q;
    if (in_accept) begin
      if (phase_q == PhSkip) begin
        phase_d = in_data_i.last ? PhStart : PhSkip;
      end else begin
        phase_d = next_phase;
      end
    end
  end

  // Characters after the stop carry no work for the back end.
  assign push_o            = in_accept && (phase_q != PhSkip);
  assign push_data_o.op    = op;
  assign push_data_o.digit = is_digit ? 4'(in_data_i.ch - CharZero) : 4'd0;
  assign push_data_o.emit  = !taken || in_data_i.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhStart;
    end else begin
      phase_q <= phase_d;
    end
  end

endmodule

// ===== rtl/dtfp_queue.sv =====
`timescale 1ns / 1ps

module dtfp_queue import dtfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  dtfp_entry_t push_data_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        valid_o,
  output dtfp_entry_t data_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

  dtfp_entry_t      mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/dtfp_back.sv =====
`timescale 1ns / 1ps

module dtfp_back import dtfp_pkg::*; #(
  parameter logic [31:0] MAX_LENGTH = DefaultMaxLength
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  dtfp_entry_t q_data_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output dtfp_out_t   out_data_o
);

  localparam logic [15:0] CountLimit =
    (MAX_LENGTH < 32'd65535) ? MAX_LENGTH[15:0] : 16'hFFFF;

  logic        neg_q, neg_d;
  logic [31:0] int_q, int_d;
  logic [31:0] frac_q, frac_d;
  logic [31:0] scale_q, scale_d;
  logic [15:0] count_q, count_d;
  logic        sat_q, sat_d;

  logic [35:0] int_sum;
  logic [35:0] frac_term;
  logic [36:0] frac_sum;
  logic [63:0] scale_prod;

  // Result stage: magnitude and sign, negated on the way to the output register.
  logic        res_valid_q, res_valid_d;
  logic        res_load;
  logic        res_adv;
  logic [63:0] res_mag_q;
  logic        res_neg_q;
  logic [15:0] res_len_q;
  logic        res_ovf_q;

  logic        out_valid_q, out_valid_d;
  dtfp_out_t   out_data_q;

  assign res_adv = res_valid_q && (!out_valid_q || !out_stall_i);
  assign pop_o   = q_valid_i && (!q_data_i.emit || !res_valid_q || res_adv);

  assign int_sum    = {1'b0, int_q, 3'b000} + {3'b000, int_q, 1'b0} + {32'd0, q_data_i.digit};
  assign frac_term  = {32'd0, q_data_i.digit} * {4'd0, scale_q};
  assign frac_sum   = {5'd0, frac_q} + {1'b0, frac_term};
  assign scale_prod = {32'd0, scale_q} * {32'd0, TenthQ32};

  always_comb begin
    neg_d   = neg_q;
    int_d   = int_q;
    frac_d  = frac_q;
    scale_d = scale_q;
    count_d = count_q;
    sat_d   = sat_q;
    if (pop_o) begin
      unique case (q_data_i.op) inside
        OP_NONE: begin
        end
        OP_NEG: begin
          neg_d = 1'b1;
        end
        OP_POS, OP_DOT: begin
        end
        OP_INT: begin
          if (int_sum > {4'd0, IntLimit}) begin
            int_d = IntLimit;
            sat_d = 1'b1;
          end else begin
            int_d = int_sum[31:0];
          end
        end
        OP_FRAC: begin
          frac_d  = (frac_sum[36:32] != '0) ? 32'hFFFF_FFFF : frac_sum[31:0];
          scale_d = scale_prod[63:32];
        end
        default: begin
        end
      endcase
      if (q_data_i.op != OP_NONE && count_q < CountLimit) begin
        count_d = count_q + 16'd1;
      end
    end
  end

  assign res_load = pop_o && q_data_i.emit;

  always_comb begin
    res_valid_d = res_valid_q;
    if (res_load) begin
      res_valid_d = 1'b1;
    end else if (res_adv) begin
      res_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (res_adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_q       <= 1'b0;
      int_q       <= '0;
      frac_q      <= '0;
      scale_q     <= TenthQ32;
      count_q     <= '0;
      sat_q       <= 1'b0;
      res_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      out_valid_q <= out_valid_d;
      // Once a number is closed the accumulators start over for the next string.
      if (res_load) begin
        neg_q   <= 1'b0;
        int_q   <= '0;
        frac_q  <= '0;
        scale_q <= TenthQ32;
        count_q <= '0;
        sat_q   <= 1'b0;
      end else begin
        neg_q   <= neg_d;
        int_q   <= int_d;
        frac_q  <= frac_d;
        scale_q <= scale_d;
        count_q <= count_d;
        sat_q   <= sat_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_mag_q <= {int_d, frac_d};
      res_neg_q <= neg_d;
      res_len_q <= count_d;
      res_ovf_q <= sat_d;
    end
    if (res_adv) begin
      out_data_q.value       <= res_neg_q ? (64'd0 - res_mag_q) : res_mag_q;
      out_data_q.used_length <= res_len_q;
      out_data_q.overflow    <= res_ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== rtl/decimal_text_to_fixed_parser_unit.sv =====
`timescale 1ns / 1ps

// Decimal text to signed Q32.32 parser.
// Input channel: one 16-bit character per transaction with a last flag that
// closes the string. Output channel: one transaction per string carrying the
// value, the number of characters consumed and the integer overflow flag.
// Both channels move a transaction when valid is high and stall is low.
// The front end classifies each character against the parse phase and sends
// it through a two-entry queue to the back end, which runs one accumulator
// step per cycle while it can pop (a multiply-by-ten add for integer digits,
// a 4x32 multiply-add plus a 32x32 scale multiply for fraction digits).
// Throughput is one character per cycle while in_stall_o is low.
// The character ending the parse goes through the queue, the result stage and
// the output register before its result is valid. Characters after the end of
// the number are taken at full rate and dropped until the one flagged last.
// While the output is stalled the result holds; the result stage and the queue
// keep absorbing characters, and in_stall_o rises only once the queue fills.
// Reset clears the parse state, the queue and both result stages.

module decimal_text_to_fixed_parser_unit import dtfp_pkg::*; #(
  parameter logic [31:0] MAX_LENGTH = DefaultMaxLength
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  dtfp_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output dtfp_out_t out_data_o
);

  logic        push;
  dtfp_entry_t push_data;
  logic        q_full;
  logic        pop;
  logic        q_valid;
  dtfp_entry_t q_data;

  dtfp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  dtfp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  dtfp_back #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/dtfp_checker.sv =====
`timescale 1ns / 1ps

module dtfp_checker import dtfp_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input dtfp_out_t out_data_o
);

  // A stalled result stays offered and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  // Nothing consumed means nothing accumulated.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.used_length == 16'd0 |-> out_data_o.value == 64'sd0)
    else $error("nonzero value with zero used length");

  // Saturation leaves the integer part at its limit, before or after negation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.overflow |->
      out_data_o.value[63:32] == 32'h7FFF_FFFF ||
      out_data_o.value[63:32] == 32'h8000_0000 ||
      out_data_o.value[63:32] == 32'h8000_0001)
    else $error("overflow flag without a saturated integer part");

  // Exceeding the integer limit takes at least ten digits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.overflow |-> out_data_o.used_length >= 16'd10)
    else $error("overflow reported with too few characters");

endmodule

bind decimal_text_to_fixed_parser_unit dtfp_checker u_dtfp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ===== test/decimal_text_to_fixed_parser_unit_tb.sv =====
`timescale 1ns / 1ps

module decimal_text_to_fixed_parser_unit_tb;
  import dtfp_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned DrainCycles = 20;
  localparam logic [15:0] CountCap =
      (DefaultMaxLength < 32'd65535) ? DefaultMaxLength[15:0] : 16'hFFFF;

  typedef enum logic [1:0] {
    PS_START,
    PS_INT,
    PS_FRAC,
    PS_SKIP
  } parse_phase_e;

  logic      clk = 1'b1;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  dtfp_in_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  dtfp_out_t out_data_o;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycles = 0;
  int unsigned errors = 0;
  int unsigned chars_sent = 0;
  int unsigned strings_sent = 0;
  int unsigned results_seen = 0;

  // Predictor state of the parser.
  parse_phase_e mdl_phase;
  logic         mdl_negative;
  logic [31:0]  mdl_integer;
  logic [31:0]  mdl_fraction;
  logic [31:0]  mdl_scale;
  logic [15:0]  mdl_count;
  logic         mdl_saturated;

  dtfp_out_t pending_results[$];

  decimal_text_to_fixed_parser_unit uut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[decimal_text_to_fixed_parser_unit] ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic clear_parse();
    mdl_phase = PS_START;
    mdl_negative = 1'b0;
    mdl_integer = '0;
    mdl_fraction = '0;
    mdl_scale = TenthQ32;
    mdl_count = '0;
    mdl_saturated = 1'b0;
  endtask

  task automatic bump_count();
    if (mdl_count < CountCap) mdl_count = mdl_count + 16'd1;
  endtask

  // Advances the predictor by one accepted character and queues the result
  // that the character causes, if any.
  task automatic parse_char(input logic [15:0] c, input logic lst);
    logic        taken;
    logic        is_digit;
    logic [63:0] d;
    logic [63:0] wide;
    logic [63:0] mag;
    dtfp_out_t   res;
    taken = 1'b0;
    is_digit = (c >= CharZero) && (c <= CharNine);
    d = is_digit ? {60'd0, c[3:0]} : 64'd0;
    if (mdl_phase == PS_SKIP) begin
      if (lst) clear_parse();
      return;
    end
    if (mdl_phase == PS_START) begin
      if (c == CharMinus) begin
        mdl_negative = 1'b1;
        taken = 1'b1;
      end else if (c == CharPlus) begin
        taken = 1'b1;
      end
      if (taken) bump_count();
      mdl_phase = PS_INT;
    end
    if (!taken) begin
      if (mdl_phase == PS_INT) begin
        if (is_digit) begin
          wide = {32'd0, mdl_integer} * 64'd10 + d;
          if (wide > {32'd0, IntLimit}) begin
            wide = {32'd0, IntLimit};
            mdl_saturated = 1'b1;
          end
          mdl_integer = wide[31:0];
          bump_count();
          taken = 1'b1;
        end else if (c == CharDot) begin
          mdl_phase = PS_FRAC;
          bump_count();
          taken = 1'b1;
        end
      end else if (mdl_phase == PS_FRAC) begin
        if (is_digit) begin
          wide = {32'd0, mdl_fraction} + d * {32'd0, mdl_scale};
          if (wide > 64'hFFFF_FFFF) wide = 64'hFFFF_FFFF;
          mdl_fraction = wide[31:0];
          wide = ({32'd0, mdl_scale} * {32'd0, TenthQ32}) >> 32;
          mdl_scale = wide[31:0];
          bump_count();
          taken = 1'b1;
        end
      end
    end
    if (taken && !lst) return;
    mag = {mdl_integer, mdl_fraction};
    res.value = mdl_negative ? -mag : mag;
    res.used_length = mdl_count;
    res.overflow = mdl_saturated;
    pending_results.push_back(res);
    if (lst) clear_parse();
    else mdl_phase = PS_SKIP;
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_char(input logic [15:0] c, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{ch: c, last: lst};
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    parse_char(c, lst);
    chars_sent++;
    if (lst) strings_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char({8'd0, s[i]}, i == s.len() - 1);
    end
  endtask

  // The result is sampled at the edge and compared a little after it, so that a
  // prediction queued at the same edge is already in place.
  initial begin
    dtfp_out_t got;
    dtfp_out_t want;
    logic      seen;
    forever begin
      @(posedge clk);
      seen = rst_ni && out_valid_o && !out_stall_i;
      got = out_data_o;
      #0.1;
      if (seen) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: result with no expectation: value=%h len=%0d ovf=%b",
                   $time, got.value, got.used_length, got.overflow);
        end else begin
          want = pending_results.pop_front();
          if (got.value !== want.value) begin
            errors++;
            $display("%0t: value expected %h actual %h", $time, want.value, got.value);
          end
          if (got.used_length !== want.used_length) begin
            errors++;
            $display("%0t: used_length expected %0d actual %0d",
                     $time, want.used_length, got.used_length);
          end
          if (got.overflow !== want.overflow) begin
            errors++;
            $display("%0t: overflow expected %b actual %b",
                     $time, want.overflow, got.overflow);
          end
        end
      end
    end
  end

  task automatic wait_results_done();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    send_text("-0");
    send_text("+");
    send_char(16'hFFFF, 1'b1);
    send_text(".");
    send_text("-.9");
    send_text("3000000000");
    send_text("1ab");
    send_text("0:");
    send_char(16'h0000, 1'b1);
    send_text("/");
  endtask

  task automatic test_exact_values();
    send_text("2147483647");
    send_text("+0.99999999999999999999");
    send_text("-12.5");
    send_text("1.2.3");
    send_text("--1");
  endtask

  // Builds one string: mostly well-formed numbers, some noise and some
  // numbers broken by a stray character. Returns the characters sent.
  task automatic send_random_string(output int unsigned counted);
    logic [15:0] txt[$];
    int unsigned kind;
    int unsigned n;
    kind = $urandom_range(9);
    if (kind == 0) begin
      n = $urandom_range(1, 4);
      repeat (n) txt.push_back(16'($urandom_range(0, 65535)));
    end else begin
      case ($urandom_range(2))
        1: txt.push_back(CharMinus);
        2: txt.push_back(CharPlus);
        default: ;
      endcase
      n = ($urandom_range(7) == 0) ? $urandom_range(8, 13) : $urandom_range(0, 4);
      repeat (n) txt.push_back(CharZero + 16'($urandom_range(9)));
      if ($urandom_range(9) < 6) begin
        txt.push_back(CharDot);
        n = ($urandom_range(7) == 0) ? $urandom_range(11, 24) : $urandom_range(0, 10);
        repeat (n) txt.push_back(CharZero + 16'($urandom_range(9)));
      end
      if (txt.size() == 0) txt.push_back(CharZero + 16'($urandom_range(9)));
      if (kind == 1 || $urandom_range(4) == 0) begin
        case ($urandom_range(3))
          0: txt.push_back(16'h002F);
          1: txt.push_back(16'h003A);
          2: txt.push_back(CharDot);
          default: txt.push_back(16'($urandom_range(0, 65535)));
        endcase
        n = $urandom_range(0, 3);
        repeat (n) txt.push_back(16'($urandom_range(0, 65535)));
      end
    end
    for (int i = 0; i < txt.size(); i++) send_char(txt[i], i == txt.size() - 1);
    counted = txt.size();
  endtask

  task automatic test_random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                                   input int unsigned items);
    int unsigned done;
    int unsigned got;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    done = 0;
    while (done < items) begin
      send_random_string(got);
      done += got;
    end
  endtask

  // The sender holds off until every expected result is back, then resumes.
  task automatic test_drain_pause();
    send_idle_pct = 0;
    recv_stall_pct = 30;
    send_text("-42.125");
    send_text("7");
    in_valid_i <= 1'b0;
    @(negedge clk);
    wait_results_done();
    send_text("+8.5x");
    send_text("9");
  endtask

  initial begin
    clear_parse();
    repeat (6) @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);
    test_directed();
    test_exact_values();
    test_random_phase(0, 0, 370);
    test_random_phase(51, 0, 370);
    test_drain_pause();
    test_random_phase(0, 51, 370);
    test_random_phase(14, 14, 370);
    in_valid_i <= 1'b0;
    @(negedge clk);
    wait_results_done();
    repeat (DrainCycles) @(negedge clk);
    if (pending_results.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
    end
    $display("Sent %0d characters in %0d strings, checked %0d results.",
             chars_sent, strings_sent, results_seen);
    $display("Covered signs, integer saturation, fractions, stray characters and idling.");
    if (errors == 0) begin
      $display("[decimal_text_to_fixed_parser_unit] OK");
    end else begin
      $display("[decimal_text_to_fixed_parser_unit] ERROR");
    end
    $finish;
  end

endmodule
